/* rtl/tdp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tdp_pkg
// shared widths, types and helpers for the trial division prime test core
// ----------------------------------------------------------------------------
package tdp_pkg;

	// width of the tested number
	localparam int NUM_BITS = 32;
	// trial divisor width: covers the square root of the largest number plus a margin
	localparam int DIV_W    = NUM_BITS / 2 + 2;
	// running square of the divisor, may step just past the largest number
	localparam int SQ_W     = NUM_BITS + 1;
	// step counter of the remainder unit
	localparam int CNT_W    = $clog2(NUM_BITS);

	typedef logic [NUM_BITS-1:0] num_t;
	typedef logic [DIV_W-1:0]    div_t;
	typedef logic [SQ_W-1:0]     sq_t;
	typedef logic [CNT_W-1:0]    cnt_t;

	// request from the sequencer to the remainder unit
	typedef struct packed {
		logic start;
		num_t dividend;
		div_t divisor;
	} rem_req_t;

	// answer from the remainder unit
	typedef struct packed {
		logic done;
		logic rem_zero;
	} rem_rsp_t;

endpackage
`default_nettype wire

/* rtl/tdp_in_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tdp_in_if
// valid/ready channel carrying the number to test
// ----------------------------------------------------------------------------
interface tdp_in_if import tdp_pkg::*; ();

	logic valid;
	logic ready;
	num_t number;

	modport source (output valid, output number, input ready);
	modport sink   (input valid, input number, output ready);

endinterface
`default_nettype wire

/* rtl/tdp_out_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tdp_out_if
// valid/ready channel carrying the primality verdict
// ----------------------------------------------------------------------------
interface tdp_out_if import tdp_pkg::*; ();

	logic valid;
	logic ready;
	logic is_prime;

	modport source (output valid, output is_prime, input ready);
	modport sink   (input valid, input is_prime, output ready);

endinterface
`default_nettype wire

/* rtl/trial_division_prime_test_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// trial_division_prime_test_core
// tests one unsigned number per transfer for primality by trial division
// ----------------------------------------------------------------------------
// usage
//   in_ch  : one number per transfer; ready is high only while no test runs
//   out_ch : one is_prime verdict per accepted number, in order
// sequence
//   zero, one and even numbers: settled in the class state, then the final
//   state loads the verdict; odd numbers: odd divisors from 3 upward are tried
//   while d*d <= number, each trial running in the one-bit-per-cycle remainder
//   unit; a prime near 2^32 takes about 32768 trials, while a composite stops
//   at its smallest odd factor
// throughput
//   one number at a time; the next transfer is taken as soon as the verdict
//   sits in the output register, even if the receiver has not taken it
// reset
//   arst_n clears the sequencer and the output valid; no result is pending
// stall
//   a held verdict waits in the output register; a finished test then waits
//   in its final state until that register frees up
// ----------------------------------------------------------------------------
module trial_division_prime_test_core import tdp_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	tdp_in_if.sink     in_ch,
	tdp_out_if.source  out_ch
);

	// sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CLASS = 3'd1;
	localparam logic [2:0] ST_CHECK = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	logic [2:0] state_q;
	num_t       n_q;
	div_t       d_q;
	sq_t        sq_q;
	logic       res_q;
	logic       out_valid_q;
	logic       out_prime_q;

	rem_req_t   rem_req;
	rem_rsp_t   rem_rsp;

	logic       sq_over;
	logic       out_free;
	logic       in_xfer;

	// divisor square past the number: no further divisor can exist
	assign sq_over  = sq_q > {1'b0, n_q};
	assign out_free = !out_valid_q || out_ch.ready;
	assign in_xfer  = in_ch.valid && in_ch.ready;

	assign in_ch.ready = (state_q == ST_IDLE);

	// kick off one remainder n mod d from the check state while the square bound still holds
	assign rem_req.start    = (state_q == ST_CHECK) && !sq_over;
	assign rem_req.dividend = n_q;
	assign rem_req.divisor  = d_q;

	tdp_rem_unit u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rem_req),
		.rsp    (rem_rsp)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_CLASS;
					end
				end
				ST_CLASS: begin
					// zero, one and even numbers are settled at once
					if (n_q < NUM_BITS'(2) || !n_q[0]) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (sq_over) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (rem_rsp.done) begin
						state_q <= rem_rsp.rem_zero ? ST_FIN : ST_CHECK;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working registers: number, divisor, running square and verdict
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			n_q  <= in_ch.number;
			d_q  <= DIV_W'(3);
			sq_q <= SQ_W'(9);
		end
		if (state_q == ST_CLASS) begin
			// two is the only even prime; odd numbers other than one default to prime
			res_q <= n_q[0] ? (n_q != NUM_BITS'(1)) : (n_q == NUM_BITS'(2));
		end
		if (state_q == ST_DIV && rem_rsp.done) begin
			if (rem_rsp.rem_zero) begin
				res_q <= 1'b0;
			end else begin
				// (d+2)^2 = d^2 + 4d + 4
				d_q  <= d_q + DIV_W'(2);
				sq_q <= sq_q + (SQ_W'(d_q) << 2) + SQ_W'(4);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			out_prime_q <= res_q;
		end
	end

	assign out_ch.valid    = out_valid_q;
	assign out_ch.is_prime = out_prime_q;

	// a transfer always starts a test
	a_xfer_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> state_q == ST_CLASS)
		else $error("accepted number did not start a test");

	// the remainder unit only answers while the sequencer waits for it
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		rem_rsp.done |-> state_q == ST_DIV)
		else $error("remainder result outside the divide state");

	// trial divisors stay odd
	a_div_odd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK || state_q == ST_DIV) |-> d_q[0])
		else $error("even trial divisor");

	// a finished test lands in the output register and frees the input
	a_fin_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_free) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("finished verdict not loaded");

endmodule
`default_nettype wire

/* rtl/tdp_rem_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tdp_rem_unit
// restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
module tdp_rem_unit import tdp_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire rem_req_t req,
	output rem_rsp_t      rsp
);

	logic         busy_q;
	logic         done_q;
	cnt_t         cnt_q;
	num_t         shift_q;
	div_t         divisor_q;
	div_t         rem_q;
	logic [DIV_W:0] trial;
	logic         fits;

	// partial remainder stays below the divisor, so shifting in one bit fits DIV_W+1
	assign trial = {rem_q, shift_q[NUM_BITS-1]};
	assign fits  = trial >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_BITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			shift_q   <= req.dividend;
			divisor_q <= req.divisor;
			rem_q     <= '0;
		end else if (busy_q) begin
			shift_q <= {shift_q[NUM_BITS-2:0], 1'b0};
			if (fits) begin
				rem_q <= DIV_W'(trial - {1'b0, divisor_q});
			end else begin
				rem_q <= trial[DIV_W-1:0];
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.rem_zero = (rem_q == '0);

endmodule
`default_nettype wire

/* tb/trial_division_prime_test_core_tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// trial_division_prime_test_core_tb
// self-checking bench for the trial division prime test core: a table of
// boundary numbers, then random numbers whose verdicts come from an in-bench
// primality predictor, under several idle and stall patterns, a long output
// hold-off and a full drain; every verdict is compared in order
// ----------------------------------------------------------------------------
module trial_division_prime_test_core_tb import tdp_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	// odd trials allowed per random number, caps the work of each test
	localparam int unsigned TRIAL_BUDGET = 400;
	// long receiver hold-off, well past the time to fill the core
	localparam int unsigned LONG_HOLD    = 600;
	localparam int          NUM_DIRECTED = 21;
	localparam int          PHASE_ITEMS  = 24;
	localparam int          PRESS_ITEMS  = 24;

	// one directed row: the number and, where obvious, its verdict
	typedef struct packed {
		num_t value;
		logic typed;
		logic verdict;
	} table_row_t;

	// one verdict in flight: the number it belongs to and its expected value
	typedef struct packed {
		num_t value;
		logic verdict;
	} verdict_due_t;

	logic clk;
	logic arst_n;

	tdp_in_if  in_ch ();
	tdp_out_if out_ch ();

	trial_division_prime_test_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	verdict_due_t verdicts_due[$];
	verdict_due_t oldest_due;
	int unsigned  fail_count = 0;

	// idle and stall chances, in percent per cycle
	int unsigned sender_idle_pct = 0;
	int unsigned recv_stall_pct  = 0;

	// long hold-off request, seen by the receiver at the following edge
	logic        hold_request;
	int unsigned hold_left = 0;

	// boundary numbers; typed verdicts only where they are plain
	table_row_t boundary_rows [NUM_DIRECTED] = '{
		'{32'd0,          1'b1, 1'b0},  // zero is not prime
		'{32'd1,          1'b1, 1'b0},  // one is not prime
		'{32'd2,          1'b1, 1'b1},  // the only even prime
		'{32'd3,          1'b1, 1'b1},  // odd, below nine: no divisor tried
		'{32'd4,          1'b1, 1'b0},  // smallest even composite
		'{32'd5,          1'b1, 1'b1},
		'{32'd7,          1'b1, 1'b1},
		'{32'd9,          1'b1, 1'b0},  // first odd square
		'{32'd15,         1'b0, 1'b0},
		'{32'd25,         1'b0, 1'b0},
		'{32'd49,         1'b0, 1'b0},
		'{32'd121,        1'b0, 1'b0},
		'{32'hFFFF_FFFF,  1'b0, 1'b0},  // all ones, odd
		'{32'hFFFF_FFFE,  1'b1, 1'b0},  // largest even
		'{32'h8000_0000,  1'b1, 1'b0},  // top bit alone
		'{32'h8000_0001,  1'b0, 1'b0},
		'{32'h5555_5555,  1'b0, 1'b0},
		'{32'hAAAA_AAAA,  1'b1, 1'b0},
		'{32'd65521,      1'b0, 1'b0},  // largest prime under 2^16
		'{32'd16744463,   1'b0, 1'b0},  // 4091 * 4093, factor found late
		'{32'd16777213,   1'b0, 1'b0}   // largest prime under 2^24
	};

	// 50 MHz clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// give up well past the slowest correct run
	initial begin
		#250_000_000;
		$display("trial_division_prime_test_core_tb: FAIL");
		$finish;
	end

	// primality by odd trial divisors up to the square root; also counts the
	// trials, which is what the core spends its time on
	function automatic logic predict_prime(input num_t value, output int unsigned trials);
		logic [63:0] n;
		logic [63:0] d;
		trials = 0;
		n = 64'(value);
		if (n < 64'd2)
			return 1'b0;
		if (n[0] == 1'b0)
			return n == 64'd2;
		for (d = 64'd3; d <= n / d; d += 64'd2) begin
			trials++;
			if (n % d == 64'd0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// random number of random width, or a product of two small odd numbers;
	// anything that would take too many trials is drawn again
	function automatic num_t random_number(input int unsigned max_bits);
		num_t        value;
		int unsigned width;
		int unsigned trials;
		do begin
			if ($urandom_range(3) == 0) begin
				value = num_t'(($urandom_range(127, 1) * 2 + 1) *
					($urandom_range(127, 1) * 2 + 1));
			end else begin
				width = $urandom_range(max_bits, 1);
				value = num_t'($urandom) & ((num_t'(1) << width) - num_t'(1));
				if (width == NUM_BITS)
					value = num_t'($urandom);
			end
			void'(predict_prime(value, trials));
		end while (trials > TRIAL_BUDGET);
		return value;
	endfunction

	// offer one number, with a random idle gap first, and note its verdict
	// once the transfer has happened
	task automatic offer_number(input num_t value, input logic typed, input logic typed_verdict);
		int unsigned trials;
		logic        verdict;
		verdict = predict_prime(value, trials);
		if (typed)
			verdict = typed_verdict;
		if ($urandom_range(99) < sender_idle_pct) begin
			in_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
		in_ch.valid  <= 1'b1;
		in_ch.number <= value;
		do @(posedge clk); while (!in_ch.ready);
		verdicts_due.push_back('{value, verdict});
	endtask

	task automatic wait_for_drain();
		while (verdicts_due.size() != 0)
			@(posedge clk);
	endtask

	// receiver: random stalls, or a long hold-off when asked for one
	always @(posedge clk) begin
		if (hold_request) begin
			hold_left    <= LONG_HOLD;
			out_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left    <= hold_left - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// verdict checker: every output transfer against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (verdicts_due.size() == 0) begin
				$error("is_prime: expected none, actual %0b", out_ch.is_prime);
				fail_count++;
			end else begin
				oldest_due = verdicts_due.pop_front();
				if (out_ch.is_prime !== oldest_due.verdict) begin
					$error("is_prime (number %0d): expected %0b, actual %0b",
						oldest_due.value, oldest_due.verdict, out_ch.is_prime);
					fail_count++;
				end
			end
		end
	end

	// stimulus
	initial begin
		arst_n       <= 1'b0;
		in_ch.valid  <= 1'b0;
		in_ch.number <= '0;
		hold_request <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// boundary table, back to back with the receiver always ready
		for (int i = 0; i < NUM_DIRECTED; i++)
			offer_number(boundary_rows[i].value, boundary_rows[i].typed,
				boundary_rows[i].verdict);

		// random numbers under four idle patterns: none, sender idle,
		// receiver stalling, both
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					sender_idle_pct = 0;
					recv_stall_pct <= 0;
				end
				1: begin
					sender_idle_pct = 75;
					recv_stall_pct <= 0;
				end
				2: begin
					sender_idle_pct = 0;
					recv_stall_pct <= 75;
				end
				default: begin
					sender_idle_pct = 31;
					recv_stall_pct <= 31;
				end
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++)
				offer_number(random_number(NUM_BITS), 1'b0, 1'b0);
		end

		// long hold-off with quick numbers, mostly small, offered without a break:
		// the output register and the finished test fill up and the input
		// stalls until the receiver comes back
		sender_idle_pct = 0;
		recv_stall_pct <= 0;
		hold_request   <= 1'b1;
		@(posedge clk);
		hold_request <= 1'b0;
		for (int i = 0; i < PRESS_ITEMS / 2; i++)
			offer_number(random_number(7), 1'b0, 1'b0);

		// sender pauses until every verdict is in, then carries on
		in_ch.valid <= 1'b0;
		wait_for_drain();
		@(posedge clk);
		for (int i = 0; i < PRESS_ITEMS / 2; i++)
			offer_number(random_number(NUM_BITS), 1'b0, 1'b0);

		in_ch.valid <= 1'b0;
		wait_for_drain();
		// wait on for any stray verdict to show itself
		repeat (20) @(posedge clk);

		if (fail_count == 0 && verdicts_due.size() == 0)
			$display("trial_division_prime_test_core_tb: PASS");
		else
			$display("trial_division_prime_test_core_tb: FAIL");
		$finish;
	end

endmodule
`default_nettype wire
